/* design/dmpc_pkg.sv */
// ---------------------------------------------------------------------------
// dmpc_pkg
// Shared types and constants of the DC motor encoder position controller.
// ---------------------------------------------------------------------------
package dmpc_pkg;

  localparam int unsigned DIV_N_W = 64;
  localparam int unsigned DIV_D_W = 48;

  localparam logic [2:0] ACT_PULSE   = 3'd0;
  localparam logic [2:0] ACT_TICK    = 3'd1;
  localparam logic [2:0] ACT_UPDATE  = 3'd2;
  localparam logic [2:0] ACT_VEL_CMD = 3'd3;
  localparam logic [2:0] ACT_POS_CMD = 3'd4;

  localparam logic [1:0] REG_TPT   = 2'd0;
  localparam logic [1:0] REG_FSR   = 2'd1;
  localparam logic [1:0] REG_PGAIN = 2'd2;
  localparam logic [1:0] REG_IGAIN = 2'd3;

  localparam logic [31:0] RPM_SCALE  = 32'd3932160000;
  localparam logic [48:0] SETTLE_LSB = 49'd1310;
  localparam logic [23:0] DUTY_MIN   = 24'd45;
  localparam logic [23:0] DUTY_MAX   = 24'd255;
  localparam logic [23:0] REV_BOOST  = 24'd30;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_VEL,
    MODE_POS
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_U_DEN,
    S_U_NUM,
    S_U_DIVGO,
    S_U_DIV,
    S_U_MODE,
    S_P_DIV,
    S_P_MUL,
    S_P_DRV,
    S_V_ERR,
    S_V_MUL,
    S_V_ACC,
    S_V_DRV,
    S_VC_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/dmpc_if.sv */
// ---------------------------------------------------------------------------
// dmpc_in_if / dmpc_out_if
// Valid/ready channels carrying the input word and the result word.
// ---------------------------------------------------------------------------
interface dmpc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic signed [31:0] target_value;

  modport source (output valid, action, target_value, input ready);
  modport sink (input valid, action, target_value, output ready);
endinterface

interface dmpc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  duty;
  logic        forward;
  logic signed [31:0] measured_rpm;
  logic        move_busy;
  logic        duty_accepted;

  modport source (output valid, duty, forward, measured_rpm, move_busy, duty_accepted,
                  input ready);
  modport sink (input valid, duty, forward, measured_rpm, move_busy, duty_accepted,
                output ready);
endinterface

/* design/dc_motor_encoder_pi_position_ctrl.sv */
// ---------------------------------------------------------------------------
// dc_motor_encoder_pi_position_ctrl
// Encoder counting, speed measurement and PI speed / P position control.
// ---------------------------------------------------------------------------
// The input channel in_word takes one action per word: encoder pulse, ms tick,
// control update, velocity command or position command. Every accepted word
// produces exactly one word on out_word with the current duty, direction,
// measured speed, busy and accepted flags. Registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce this. Pulses, ticks,
// position commands and unused actions pass straight to the output
// register. A velocity command is dominated by one pass of the 64-step
// shared divider. A control update runs the speed pass of the divider,
// then in position mode a second pass for the position; an update with
// no elapsed time skips the speed pass.
// One word is in flight at a time; in_word.ready is low while it is worked.
// A finished word waits in the output register while out_word.ready is low,
// and no new word is taken until it leaves.
// Synchronous reset restores the register defaults, forward direction,
// duty zero and an empty output register.
// ---------------------------------------------------------------------------
module dc_motor_encoder_pi_position_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  dmpc_in_if.sink           in_word,
  dmpc_out_if.source        out_word
);

  dmpc_pkg::state_t    state_r, state_nxt;
  dmpc_pkg::mode_t     mode_r;
  dmpc_pkg::div_req_t  div_req;
  dmpc_pkg::div_stat_t div_stat;
  logic [63:0]         div_q;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         prod;

  logic [15:0] tpt_r, fsr_r, pgain_r, igain_r;
  logic [31:0] tick_r, prev_r, ms_r;
  logic [31:0] speed_tgt_r, turn_tgt_r, acc_r, rpm_r;
  logic [7:0]  duty_r;
  logic        dir_r, busy_r, accf_r, rev_r;
  logic [31:0] dmag_r;
  logic        dneg_r;
  logic [47:0] den_r;
  logic [48:0] emag_r;
  logic        eneg_r;
  logic [32:0] e_r;

  logic        out_valid_r, out_dir_r, out_busy_r, out_accf_r;
  logic [7:0]  out_duty_r;
  logic [31:0] out_rpm_r;

  logic        in_fire, out_free;
  logic [15:0] tpt_eff, fsr_eff;
  logic [31:0] d_diff, t_mag, tick_mag;
  logic [49:0] pos_s, err_s;
  logic [32:0] e_v;
  logic [31:0] c_mag;
  logic [33:0] c_s, acc_sum;
  logic [34:0] v_s, v_mag;
  logic [18:0] v_q;
  logic [23:0] p24, pvc;
  logic [7:0]  p_duty;

  dmpc_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  dmpc_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .stat(div_stat), .quotient(div_q)
  );

  assign out_free = !out_valid_r || out_word.ready;
  assign in_fire  = in_word.valid && in_word.ready;
  assign tpt_eff  = (tpt_r == 16'd0) ? 16'd1 : tpt_r;
  assign fsr_eff  = (fsr_r == 16'd0) ? 16'd1 : fsr_r;

  always_comb begin
    d_diff   = tick_r - prev_r;
    t_mag    = in_word.target_value[31] ? (~in_word.target_value + 32'd1)
                                        : in_word.target_value;
    tick_mag = tick_r[31] ? (~tick_r + 32'd1) : tick_r;
    pos_s    = tick_r[31] ? (~{2'b0, div_q[47:0]} + 50'd1) : {2'b0, div_q[47:0]};
    err_s    = {{18{turn_tgt_r[31]}}, turn_tgt_r} - pos_s;
    e_v      = {speed_tgt_r[31], speed_tgt_r} - {rpm_r[31], rpm_r};
    c_mag    = prod[47:16];
    c_s      = (eneg_r ^ !dir_r) ? (~{2'b0, c_mag} + 34'd1) : {2'b0, c_mag};
    acc_sum  = {{2{acc_r[31]}}, acc_r} + c_s;
    v_s      = {e_r[32], e_r, 1'b0} + {{3{acc_r[31]}}, acc_r};
    v_mag    = v_s[34] ? (~v_s + 35'd1) : v_s;
    v_q      = v_mag[34:16];
    p24      = prod[47:24];
    pvc      = div_q[23:0] + (rev_r ? dmpc_pkg::REV_BOOST : 24'd0);
    if (emag_r[48:32] != 17'd0) begin
      p_duty = (pgain_r == 16'd0) ? dmpc_pkg::DUTY_MIN[7:0] : dmpc_pkg::DUTY_MAX[7:0];
    end else if (p24 < dmpc_pkg::DUTY_MIN) begin
      p_duty = dmpc_pkg::DUTY_MIN[7:0];
    end else if (p24 > dmpc_pkg::DUTY_MAX) begin
      p_duty = dmpc_pkg::DUTY_MAX[7:0];
    end else begin
      p_duty = p24[7:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmpc_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_word.action == dmpc_pkg::ACT_UPDATE) begin
            state_nxt = dmpc_pkg::S_U_DEN;
          end else if (in_word.action == dmpc_pkg::ACT_VEL_CMD) begin
            state_nxt = dmpc_pkg::S_VC_DIV;
          end else begin
            state_nxt = dmpc_pkg::S_OUT;
          end
        end
      end
      dmpc_pkg::S_U_DEN:   state_nxt = dmpc_pkg::S_U_NUM;
      dmpc_pkg::S_U_NUM:   state_nxt = dmpc_pkg::S_U_DIVGO;
      dmpc_pkg::S_U_DIVGO: begin
        state_nxt = (den_r == 48'd0) ? dmpc_pkg::S_U_MODE : dmpc_pkg::S_U_DIV;
      end
      dmpc_pkg::S_U_DIV: if (div_stat.done) state_nxt = dmpc_pkg::S_U_MODE;
      dmpc_pkg::S_U_MODE: begin
        unique case (mode_r)
          dmpc_pkg::MODE_POS: state_nxt = dmpc_pkg::S_P_DIV;
          dmpc_pkg::MODE_VEL: state_nxt = dmpc_pkg::S_V_ERR;
          default:            state_nxt = dmpc_pkg::S_OUT;
        endcase
      end
      dmpc_pkg::S_P_DIV:  if (div_stat.done) state_nxt = dmpc_pkg::S_P_MUL;
      dmpc_pkg::S_P_MUL:  state_nxt = dmpc_pkg::S_P_DRV;
      dmpc_pkg::S_P_DRV:  state_nxt = dmpc_pkg::S_OUT;
      dmpc_pkg::S_V_ERR:  state_nxt = dmpc_pkg::S_V_MUL;
      dmpc_pkg::S_V_MUL:  state_nxt = dmpc_pkg::S_V_ACC;
      dmpc_pkg::S_V_ACC:  state_nxt = dmpc_pkg::S_V_DRV;
      dmpc_pkg::S_V_DRV:  state_nxt = dmpc_pkg::S_OUT;
      dmpc_pkg::S_VC_DIV: if (div_stat.done) state_nxt = dmpc_pkg::S_OUT;
      dmpc_pkg::S_OUT:    if (out_free) state_nxt = dmpc_pkg::S_IDLE;
      default:            state_nxt = dmpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_word.ready    = 1'b0;
    mul_a            = 32'd0;
    mul_b            = 32'd0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      dmpc_pkg::S_IDLE: begin
        in_word.ready    = out_free;
        div_req.start    = in_fire && (in_word.action == dmpc_pkg::ACT_VEL_CMD);
        div_req.dividend = {40'd0, 24'(t_mag[31:16]) * 24'd255};
        div_req.divisor  = {32'd0, fsr_eff};
      end
      dmpc_pkg::S_U_DEN: begin
        mul_a = ms_r;
        mul_b = {16'd0, tpt_eff};
      end
      dmpc_pkg::S_U_NUM: begin
        mul_a = dmag_r;
        mul_b = dmpc_pkg::RPM_SCALE;
      end
      dmpc_pkg::S_U_DIVGO: begin
        div_req.start    = (den_r != 48'd0);
        div_req.dividend = prod;
        div_req.divisor  = den_r;
      end
      dmpc_pkg::S_U_MODE: begin
        div_req.start    = (mode_r == dmpc_pkg::MODE_POS);
        div_req.dividend = {16'd0, tick_mag, 16'd0};
        div_req.divisor  = {32'd0, tpt_eff};
      end
      dmpc_pkg::S_P_MUL: begin
        mul_a = emag_r[31:0];
        mul_b = {16'd0, pgain_r};
      end
      dmpc_pkg::S_V_MUL: begin
        mul_a = emag_r[31:0];
        mul_b = {16'd0, igain_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmpc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpt_r   <= 16'd360;
      fsr_r   <= 16'd200;
      pgain_r <= 16'd256;
      igain_r <= 16'd655;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmpc_pkg::REG_TPT:   tpt_r   <= cfg_data;
        dmpc_pkg::REG_FSR:   fsr_r   <= cfg_data;
        dmpc_pkg::REG_PGAIN: pgain_r <= cfg_data;
        dmpc_pkg::REG_IGAIN: igain_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      prev_r      <= '0;
      ms_r        <= '0;
      speed_tgt_r <= '0;
      turn_tgt_r  <= '0;
      acc_r       <= '0;
      rpm_r       <= '0;
      duty_r      <= '0;
      dir_r       <= 1'b1;
      mode_r      <= dmpc_pkg::MODE_IDLE;
      busy_r      <= 1'b0;
      accf_r      <= 1'b1;
    end else begin
      unique case (state_r)
        dmpc_pkg::S_IDLE: begin
          if (in_fire) begin
            priority case (in_word.action)
              dmpc_pkg::ACT_PULSE: tick_r <= dir_r ? tick_r + 32'd1 : tick_r - 32'd1;
              dmpc_pkg::ACT_TICK:  ms_r <= ms_r + 32'd1;
              dmpc_pkg::ACT_UPDATE: begin
                dneg_r <= d_diff[31];
                dmag_r <= d_diff[31] ? (~d_diff + 32'd1) : d_diff;
              end
              dmpc_pkg::ACT_VEL_CMD: begin
                rev_r <= (!in_word.target_value[31] && !dir_r) ||
                         ((in_word.target_value[31] || (in_word.target_value == 32'sd0))
                          && dir_r);
                dir_r       <= !in_word.target_value[31];
                mode_r      <= dmpc_pkg::MODE_VEL;
                speed_tgt_r <= in_word.target_value;
              end
              dmpc_pkg::ACT_POS_CMD: begin
                mode_r     <= dmpc_pkg::MODE_POS;
                tick_r     <= '0;
                turn_tgt_r <= in_word.target_value;
                busy_r     <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        dmpc_pkg::S_U_NUM: den_r <= prod[47:0];
        dmpc_pkg::S_U_DIVGO: begin
          prev_r <= tick_r;
          ms_r   <= '0;
          if (den_r == 48'd0) rpm_r <= '0;
        end
        dmpc_pkg::S_U_DIV: begin
          if (div_stat.done) begin
            if (!dneg_r) begin
              rpm_r <= (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
            end else begin
              rpm_r <= (div_q >= 64'h8000_0000) ? 32'h8000_0000 : (~div_q[31:0] + 32'd1);
            end
          end
        end
        dmpc_pkg::S_P_DIV: begin
          if (div_stat.done) begin
            eneg_r <= err_s[49];
            emag_r <= err_s[49] ? ((~err_s[48:0]) + 49'd1) : err_s[48:0];
          end
        end
        dmpc_pkg::S_P_DRV: begin
          dir_r  <= !eneg_r;
          duty_r <= p_duty;
          accf_r <= 1'b1;
          if (emag_r <= dmpc_pkg::SETTLE_LSB) busy_r <= 1'b0;
        end
        dmpc_pkg::S_V_ERR: begin
          e_r    <= e_v;
          eneg_r <= e_v[32];
          emag_r <= {16'd0, e_v[32] ? (~e_v + 33'd1) : e_v};
        end
        dmpc_pkg::S_V_ACC: begin
          if (!acc_sum[33] && (acc_sum[32:31] != 2'b00)) begin
            acc_r <= 32'h7FFF_FFFF;
          end else if (acc_sum[33] && (acc_sum[32:31] != 2'b11)) begin
            acc_r <= 32'h8000_0000;
          end else begin
            acc_r <= acc_sum[31:0];
          end
        end
        dmpc_pkg::S_V_DRV: begin
          if ((v_s[34] && (v_q != 19'd0)) || (v_q > 19'd255)) begin
            accf_r <= 1'b0;
          end else begin
            duty_r <= v_q[7:0];
            accf_r <= 1'b1;
          end
        end
        dmpc_pkg::S_VC_DIV: begin
          if (div_stat.done) begin
            if (pvc > dmpc_pkg::DUTY_MAX) begin
              accf_r <= 1'b0;
            end else begin
              duty_r <= pvc[7:0];
              accf_r <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == dmpc_pkg::S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == dmpc_pkg::S_OUT) && out_free) begin
      out_duty_r <= duty_r;
      out_dir_r  <= dir_r;
      out_rpm_r  <= rpm_r;
      out_busy_r <= busy_r;
      out_accf_r <= accf_r;
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.duty          = out_duty_r;
  assign out_word.forward       = out_dir_r;
  assign out_word.measured_rpm  = out_rpm_r;
  assign out_word.move_busy     = out_busy_r;
  assign out_word.duty_accepted = out_accf_r;

endmodule

/* design/dmpc_mul.sv */
// ---------------------------------------------------------------------------
// dmpc_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module dmpc_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

  assign prod = prod_r;

endmodule

/* design/dmpc_div.sv */
// ---------------------------------------------------------------------------
// dmpc_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dmpc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dmpc_pkg::div_req_t        req,
  output dmpc_pkg::div_stat_t       stat,
  output logic [dmpc_pkg::DIV_N_W-1:0] quotient
);

  logic [dmpc_pkg::DIV_N_W-1:0] dvd_r;
  logic [dmpc_pkg::DIV_D_W-1:0] dsr_r;
  logic [dmpc_pkg::DIV_D_W-1:0] rem_r;
  logic [5:0]                   cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [dmpc_pkg::DIV_D_W:0]   rem_sh;
  logic [dmpc_pkg::DIV_D_W:0]   diff;
  logic                         qbit;

  always_comb begin
    rem_sh = {rem_r, dvd_r[dmpc_pkg::DIV_N_W-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    qbit   = (rem_sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == 6'd63)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[dmpc_pkg::DIV_D_W-1:0] : rem_sh[dmpc_pkg::DIV_D_W-1:0];
      dvd_r <= {dvd_r[dmpc_pkg::DIV_N_W-2:0], qbit};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

endmodule

/* design/dmpc_checker.sv */
// ---------------------------------------------------------------------------
// dmpc_checker
// Port-level checks of the controller's handshakes, bound to the top level.
// ---------------------------------------------------------------------------
module dmpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_duty,
  input logic        out_forward,
  input logic [31:0] out_rpm,
  input logic        out_busy,
  input logic        out_accepted
);

  a_reset_state: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("Block not empty and ready after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second word was taken while one is in work.");

  a_no_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("Input taken while a stalled result waits.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty) && $stable(out_forward)
      && $stable(out_rpm) && $stable(out_busy) && $stable(out_accepted))
    else $error("Stalled result word changed.");

endmodule

bind dc_motor_encoder_pi_position_ctrl dmpc_checker u_dmpc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_word.valid),
  .in_ready     (in_word.ready),
  .out_valid    (out_word.valid),
  .out_ready    (out_word.ready),
  .out_duty     (out_word.duty),
  .out_forward  (out_word.forward),
  .out_rpm      (out_word.measured_rpm),
  .out_busy     (out_word.move_busy),
  .out_accepted (out_word.duty_accepted)
);
